### src/at_acf_pkg.sv
// shared types, constants and the verdict function of the command filter
package at_acf_pkg;

   // default raw length limit and summary queue depth
   localparam int MAX_LEN_DEFAULT     = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // character and count widths
   localparam int CHAR_W      = 7;
   localparam int KEPT_W      = 5;
   localparam int TEXT_DEPTH  = 6;
   localparam int KEPT_MAX    = 31;
   localparam int ALLOW_COUNT = 23;

   // verdict codes
   typedef enum logic [1:0] {
      VERDICT_ALLOWED   = 2'd0,
      VERDICT_FORBIDDEN = 2'd1,
      VERDICT_MALFORMED = 2'd2
   } verdict_type;

   // one finished command as handed from the front to the back
   typedef struct packed {
      logic                                bad;
      logic [KEPT_W-1:0]                   kept;
      logic [TEXT_DEPTH-1:0][CHAR_W-1:0]   chars;
   } summary_type;

   localparam int SUMMARY_W = $bits(summary_type);

   // byte classes
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;

   // allowlist, left aligned and padded with spaces, which are never kept
   localparam logic [47:0] ALLOW_TEXT [ALLOW_COUNT] = '{
      "ATZ   ", "ATD   ", "ATWS  ", "ATE0  ", "ATE1  ", "ATL0  ", "ATL1  ",
      "ATS0  ", "ATS1  ", "ATH0  ", "ATH1  ", "ATM0  ", "ATM1  ", "ATAT0 ",
      "ATAT1 ", "ATAT2 ", "ATCAF0", "ATCAF1", "ATDP  ", "ATDPN ", "ATRV  ",
      "ATI   ", "AT@1  "
   };
   localparam logic [2:0] ALLOW_LEN [ALLOW_COUNT] = '{
      3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5,
      3'd5, 3'd5, 3'd6, 3'd6, 3'd4, 3'd5, 3'd4,
      3'd3, 3'd4
   };

   localparam logic [7:0] CH_A    = "A";
   localparam logic [7:0] CH_T    = "T";
   localparam logic [7:0] CH_S    = "S";
   localparam logic [7:0] CH_P    = "P";
   localparam logic [7:0] CH_F    = "F";
   localparam logic [7:0] CH_0    = "0";
   localparam logic [7:0] CH_9    = "9";
   localparam logic [7:0] CH_LO_A = "a";
   localparam logic [7:0] CH_LO_Z = "z";

   // upper-case hex digit
   function automatic logic is_hex(input logic [CHAR_W-1:0] c);
      return (c >= CH_0[CHAR_W-1:0] && c <= CH_9[CHAR_W-1:0]) ||
             (c >= CH_A[CHAR_W-1:0] && c <= CH_F[CHAR_W-1:0]);
   endfunction

   // exact match against any allowlist entry
   function automatic logic allow_hit(input summary_type s);
      logic hit;
      logic same;
      hit = 1'b0;
      for (int p = 0; p < ALLOW_COUNT; p++) begin
         same = (s.kept == KEPT_W'(ALLOW_LEN[p]));
         for (int i = 0; i < TEXT_DEPTH; i++) begin
            // low seven bits of character i of the entry
            if (3'(i) < ALLOW_LEN[p] &&
                s.chars[i] != ALLOW_TEXT[p][46-8*i -: CHAR_W]) begin
               same = 1'b0;
            end
         end
         hit = hit | same;
      end
      return hit;
   endfunction

   // verdict for one finished command
   function automatic verdict_type judge(input summary_type s);
      logic sp_form;
      logic st_form;
      sp_form = (s.kept >= KEPT_W'(4)) && s.chars[2] == CH_S[CHAR_W-1:0] &&
                s.chars[3] == CH_P[CHAR_W-1:0];
      st_form = (s.kept == KEPT_W'(6)) && s.chars[2] == CH_S[CHAR_W-1:0] &&
                s.chars[3] == CH_T[CHAR_W-1:0] && is_hex(s.chars[4]) &&
                is_hex(s.chars[5]);
      if (s.bad || s.kept < KEPT_W'(3)) begin
         return VERDICT_MALFORMED;
      end
      if (s.chars[0] != CH_A[CHAR_W-1:0] || s.chars[1] != CH_T[CHAR_W-1:0]) begin
         return VERDICT_FORBIDDEN;
      end
      if (s.kept > KEPT_W'(6)) begin
         return VERDICT_FORBIDDEN;
      end
      if (allow_hit(s)) begin
         return VERDICT_ALLOWED;
      end
      if (sp_form) begin
         if (s.kept == KEPT_W'(5) && is_hex(s.chars[4])) begin
            return VERDICT_ALLOWED;
         end
         if (s.kept == KEPT_W'(6) && s.chars[4] == CH_A[CHAR_W-1:0] &&
             is_hex(s.chars[5])) begin
            return VERDICT_ALLOWED;
         end
         return VERDICT_FORBIDDEN;
      end
      if (st_form) begin
         return VERDICT_ALLOWED;
      end
      return VERDICT_FORBIDDEN;
   endfunction

endpackage

### src/at_acf_fifo.sv
// small register queue between the front and the back of the command filter
module at_acf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // status
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count past depth");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> !empty)
      else $error("queue empty after a push");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> !full)
      else $error("queue full after a pop");
`endif

endmodule

### src/at_acf_front.sv
// front end: takes command bytes, classifies them and builds a command summary
module at_acf_front #(
   parameter int MAX_LEN = at_acf_pkg::MAX_LEN_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   input  logic                    sum_full,
   output logic                    sum_push,
   output at_acf_pkg::summary_type sum_word
);
   import at_acf_pkg::*;

   localparam int RAW_W = $clog2(MAX_LEN + 1);

   logic [RAW_W-1:0]                  raw_ff, raw_in, raw_step;
   logic [KEPT_W-1:0]                 kept_ff, kept_in, kept_step;
   logic                              bad_ff, bad_in, bad_step;
   logic [TEXT_DEPTH-1:0][CHAR_W-1:0] chars_ff, chars_in, chars_step;
   logic                              accept;
   logic                              white;
   logic                              unprintable;
   logic                              keep;
   logic                              raw_over;
   logic [CHAR_W-1:0]                 folded;

   assign accept = req_push && !sum_full;

   // byte classification and case folding
   always_comb begin
      white = (req_data_byte == BYTE_SPACE) || (req_data_byte == BYTE_TAB) ||
              (req_data_byte == BYTE_CR) || (req_data_byte == BYTE_LF);
      unprintable = !white && ((req_data_byte < BYTE_SPACE) || (req_data_byte >= BYTE_DEL));
      keep        = !white && !unprintable;
      folded      = req_data_byte[CHAR_W-1:0];
      if (req_data_byte >= CH_LO_A && req_data_byte <= CH_LO_Z) begin
         folded[5] = 1'b0;
      end
   end

   // state after this word is counted
   always_comb begin
      raw_over   = (raw_ff == RAW_W'(MAX_LEN));
      raw_step   = raw_over ? raw_ff : raw_ff + RAW_W'(1);
      bad_step   = bad_ff || raw_over || unprintable;
      kept_step  = kept_ff;
      chars_step = chars_ff;
      if (keep) begin
         if (kept_ff != KEPT_W'(KEPT_MAX)) begin
            kept_step = kept_ff + KEPT_W'(1);
         end
         for (int i = 0; i < TEXT_DEPTH; i++) begin
            if (kept_ff == KEPT_W'(i)) begin
               chars_step[i] = folded;
            end
         end
      end
   end

   // summary out and restart after the last word
   always_comb begin
      sum_push       = accept && req_last_byte;
      sum_word.bad   = bad_step;
      sum_word.kept  = kept_step;
      sum_word.chars = chars_step;
      raw_in         = raw_ff;
      kept_in        = kept_ff;
      bad_in         = bad_ff;
      chars_in       = chars_ff;
      if (accept) begin
         chars_in = chars_step;
         if (req_last_byte) begin
            raw_in  = '0;
            kept_in = '0;
            bad_in  = 1'b0;
         end else begin
            raw_in  = raw_step;
            kept_in = kept_step;
            bad_in  = bad_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff   <= '0;
         kept_ff  <= '0;
         bad_ff   <= 1'b0;
         chars_ff <= '0;
      end else begin
         raw_ff   <= raw_in;
         kept_ff  <= kept_in;
         bad_ff   <= bad_in;
         chars_ff <= chars_in;
      end
   end

`ifndef SYNTHESIS
   a_raw_bound: assert property (@(posedge clock) disable iff (reset)
      raw_ff <= RAW_W'(MAX_LEN))
      else $error("raw count past limit");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> raw_ff == '0 && kept_ff == '0 && !bad_ff)
      else $error("counters not cleared after last word");
   a_kept_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_last_byte && keep && kept_ff != KEPT_W'(KEPT_MAX)
      |=> kept_ff == $past(kept_ff) + KEPT_W'(1))
      else $error("kept count did not advance");
`endif

endmodule

### src/at_acf_judge.sv
// back end: judges one command summary and holds the verdict for the receiver
module at_acf_judge (
   input  logic                    clock,
   input  logic                    reset,
   input  at_acf_pkg::summary_type sum_word,
   input  logic                    sum_empty,
   output logic                    sum_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic [1:0]              rsp_verdict
);
   import at_acf_pkg::*;

   logic        valid_ff, valid_in;
   verdict_type verdict_ff, verdict_in;
   logic        slot_free;

   // take a new summary whenever the output slot is free or being drained
   assign slot_free   = !valid_ff || rsp_pop;
   assign sum_pop     = slot_free && !sum_empty;
   assign rsp_empty   = !valid_ff;
   assign rsp_verdict = verdict_ff;

   always_comb begin
      valid_in   = valid_ff;
      verdict_in = verdict_ff;
      if (slot_free) begin
         valid_in = !sum_empty;
      end
      if (sum_pop) begin
         verdict_in = judge(sum_word);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

`ifndef SYNTHESIS
   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      sum_pop |=> !rsp_empty)
      else $error("taken summary gave no verdict");
   a_bad_malformed: assert property (@(posedge clock) disable iff (reset)
      sum_pop && sum_word.bad |=> verdict_ff == VERDICT_MALFORMED)
      else $error("bad word not judged malformed");
   a_short_malformed: assert property (@(posedge clock) disable iff (reset)
      sum_pop && sum_word.kept < KEPT_W'(3) |=> verdict_ff == VERDICT_MALFORMED)
      else $error("short command not judged malformed");
`endif

endmodule

### src/at_command_allowlist_filter.sv
// Command allowlist filter: checks one adapter command and returns one verdict.
// Input channel: push a command one word per cycle (req_data_byte), with
//   req_last_byte high on its final word; a word is taken when req_push is
//   high and req_full is low. Whitespace is dropped, letters are folded.
// Result channel: one verdict per command on rsp_verdict (0 allowed,
//   1 forbidden, 2 malformed) while rsp_empty is low; rsp_pop takes it.
// Throughput: one word per cycle while req_full is low, one verdict per cycle
//   for short commands while rsp_pop is high; words are classified as taken.
// Path: the edge that takes the last word writes the summary queue; the
//   judge stage loads the summary from there when its slot is free.
// Stall: if rsp_pop stays low the judge holds its verdict and the summary
//   queue (QUEUE_DEPTH commands) fills; req_full then rises and holds off new
//   words until a verdict is taken. A partial command waits in the front.
// Reset: synchronous, active high; clears all counters, flags and queues,
//   so no partial command survives; req_full is low the cycle after.
module at_command_allowlist_filter #(
   parameter int MAX_LEN     = at_acf_pkg::MAX_LEN_DEFAULT,
   parameter int QUEUE_DEPTH = at_acf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_verdict
);
   import at_acf_pkg::*;

   summary_type sum_wr;
   summary_type sum_rd;
   logic        sum_push;
   logic        sum_full;
   logic        sum_pop;
   logic        sum_empty;

   assign req_full = sum_full;

   // word intake and classification
   at_acf_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .sum_full      (sum_full),
      .sum_push      (sum_push),
      .sum_word      (sum_wr)
   );

   // summary queue between front and back
   at_acf_fifo #(
      .WIDTH (SUMMARY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (sum_push),
      .wdata (sum_wr),
      .full  (sum_full),
      .pop   (sum_pop),
      .rdata (sum_rd),
      .empty (sum_empty)
   );

   // verdict stage
   at_acf_judge u_judge (
      .clock       (clock),
      .reset       (reset),
      .sum_word    (sum_rd),
      .sum_empty   (sum_empty),
      .sum_pop     (sum_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_verdict (rsp_verdict)
   );

`ifndef SYNTHESIS
   a_reset_idle: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("block not idle after reset");
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_verdict != 2'd3)
      else $error("unused verdict code shown");
   a_empty_queue_no_stall: assert property (@(posedge clock) disable iff (reset)
      sum_empty |-> !req_full)
      else $error("input stalled with an empty queue");
`endif

endmodule

### tb/sv/tb_at_command_allowlist_filter.sv
// self-checking testbench for the command allowlist filter
`timescale 1ns / 100ps

module tb_at_command_allowlist_filter;
   import at_acf_pkg::*;

   // timing and run size
   localparam int     HALF_PERIOD   = 4;
   localparam int     RESET_CYCLES  = 10;
   localparam int     MAX_IDLE      = 16;
   localparam int     DRAIN_CYCLES  = 16;
   localparam int     RANDOM_WORDS  = 1300;
   localparam longint RUN_LIMIT_NS  = 5_000_000;

   // command rules as the block is built
   localparam int RAW_LIMIT     = MAX_LEN_DEFAULT;
   localparam int STORE_SLOTS   = 16;
   localparam int KEPT_CAP      = 31;
   localparam int LONGEST_FORM  = 6;
   localparam int ALLOWED_FORMS = 23;

   // directed table helpers
   localparam int   NO_ODD = -1;
   localparam logic PIN    = 1'b1;
   localparam logic CALC   = 1'b0;

   // byte classes
   localparam logic [7:0] SPACE_BYTE  = 8'h20;
   localparam logic [7:0] TAB_BYTE    = 8'h09;
   localparam logic [7:0] CR_BYTE     = 8'h0D;
   localparam logic [7:0] LF_BYTE     = 8'h0A;
   localparam logic [7:0] DEL_BYTE    = 8'h7F;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_push      = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_pop       = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [1:0] rsp_verdict;

   // one directed command
   typedef struct {
      string       text;
      int          odd_pos;
      logic [7:0]  odd_val;
      logic        pinned;
      verdict_type want;
   } plan_row_type;

   plan_row_type plan[$];
   logic [7:0]  cmd_bytes[$];

   // predictor state
   logic [6:0]  cmd_chars [STORE_SLOTS];
   int          kept_n;
   int          raw_n;
   logic        junk_seen;
   logic        pin_next;
   verdict_type pin_verdict;
   verdict_type verdicts_due[$];

   int          mismatches = 0;
   logic        quiet_push = 1'b0;

   string allow_words [ALLOWED_FORMS] = '{
      "ATZ", "ATD", "ATWS", "ATE0", "ATE1", "ATL0", "ATL1", "ATS0", "ATS1",
      "ATH0", "ATH1", "ATM0", "ATM1", "ATAT0", "ATAT1", "ATAT2",
      "ATCAF0", "ATCAF1", "ATDP", "ATDPN", "ATRV", "ATI", "AT@1"
   };

   at_command_allowlist_filter #(
      .MAX_LEN (RAW_LIMIT)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_verdict   (rsp_verdict)
   );

   // clock
   always #(HALF_PERIOD) clock = ~clock;

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   function automatic void clear_command();
      foreach (cmd_chars[i]) cmd_chars[i] = '0;
      kept_n    = 0;
      raw_n     = 0;
      junk_seen = 1'b0;
   endfunction

   function automatic logic hex_digit(input logic [6:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
   endfunction

   // exact match of the kept text against one allowlist word
   function automatic logic kept_is(input string w);
      if (w.len() != kept_n) return 1'b0;
      for (int i = 0; i < kept_n; i++) begin
         if (cmd_chars[i] != 7'(w[i])) return 1'b0;
      end
      return 1'b1;
   endfunction

   // verdict for the finished command held in the predictor
   function automatic verdict_type grade_command();
      if (junk_seen || kept_n < 3) return VERDICT_MALFORMED;
      if (cmd_chars[0] != "A" || cmd_chars[1] != "T") return VERDICT_FORBIDDEN;
      if (kept_n > LONGEST_FORM) return VERDICT_FORBIDDEN;
      foreach (allow_words[i]) begin
         if (kept_is(allow_words[i])) return VERDICT_ALLOWED;
      end
      // protocol select: one hex digit, or A and one hex digit
      if (kept_n >= 4 && cmd_chars[2] == "S" && cmd_chars[3] == "P") begin
         if (kept_n == 5 && hex_digit(cmd_chars[4])) return VERDICT_ALLOWED;
         if (kept_n == 6 && cmd_chars[4] == "A" && hex_digit(cmd_chars[5]))
            return VERDICT_ALLOWED;
         return VERDICT_FORBIDDEN;
      end
      // timeout: two hex digits
      if (kept_n == 6 && cmd_chars[2] == "S" && cmd_chars[3] == "T" &&
          hex_digit(cmd_chars[4]) && hex_digit(cmd_chars[5]))
         return VERDICT_ALLOWED;
      return VERDICT_FORBIDDEN;
   endfunction

   // fold one accepted word into the predictor
   function automatic void absorb_word(input logic [7:0] b, input logic last);
      logic [7:0] c;
      if (raw_n >= RAW_LIMIT) junk_seen = 1'b1;
      else raw_n++;
      if (!(b == SPACE_BYTE || b == TAB_BYTE || b == CR_BYTE || b == LF_BYTE)) begin
         if (b < SPACE_BYTE || b >= DEL_BYTE) begin
            junk_seen = 1'b1;
         end else begin
            c = b;
            if (c >= "a" && c <= "z") c = c - CASE_OFFSET;
            if (kept_n < STORE_SLOTS) cmd_chars[kept_n] = c[6:0];
            if (kept_n < KEPT_CAP) kept_n++;
         end
      end
      if (last) begin
         verdicts_due.push_back(pin_next ? pin_verdict : grade_command());
         pin_next = 1'b0;
         clear_command();
      end
   endfunction

   // drive one word with a random lead-in gap, wait for acceptance
   task automatic push_word(input logic [7:0] b, input logic last);
      int gap;
      gap = quiet_push ? 0 : $urandom_range(MAX_IDLE);
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_full !== 1'b0);
      absorb_word(b, last);
   endtask

   task automatic send_command();
      if ($urandom_range(7) == 0) quiet_push = !quiet_push;
      foreach (cmd_bytes[i]) push_word(cmd_bytes[i], i == cmd_bytes.size() - 1);
   endtask

   function automatic void plan_row(input string text, input int odd_pos,
                                    input logic [7:0] odd_val, input logic pinned,
                                    input verdict_type want);
      plan_row_type r;
      r.text    = text;
      r.odd_pos = odd_pos;
      r.odd_val = odd_val;
      r.pinned  = pinned;
      r.want    = want;
      plan.push_back(r);
   endfunction

   // directed commands: short, whitespace, bad bytes, length edges, each kind of allowed form
   function automatic void fill_plan();
      plan_row("ATZ",               NO_ODD, 8'h00, PIN,  VERDICT_ALLOWED);
      plan_row("AT",                NO_ODD, 8'h00, PIN,  VERDICT_MALFORMED);
      plan_row(" \t\015\n",         NO_ODD, 8'h00, PIN,  VERDICT_MALFORMED);
      plan_row("ATZ",               1,      8'h00, PIN,  VERDICT_MALFORMED);
      plan_row("ATZ",               2,      8'hFF, PIN,  VERDICT_MALFORMED);
      plan_row("ATI",               0,      8'h7F, PIN,  VERDICT_MALFORMED);
      plan_row("ATI",               2,      8'h1F, PIN,  VERDICT_MALFORMED);
      plan_row("ATD",               1,      8'h80, PIN,  VERDICT_MALFORMED);
      plan_row("XTZ",               NO_ODD, 8'h00, PIN,  VERDICT_FORBIDDEN);
      plan_row("atz\015\n",         NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row(" A t\tws \015",     NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATZZZZZZZZZZZZZZZ", NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATZ             ",  NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATZZZZZ",           NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATCAF1",            NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("AT@1",              NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATDPN",             NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATAT2",             NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATSP6",             NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATSPA9",            NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("atsp a f",          NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATSPG",             NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATSP",              NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATST0F",            NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
      plan_row("ATST0G",            NO_ODD, 8'h00, CALC, VERDICT_ALLOWED);
   endfunction

   // mostly a hex digit, sometimes lower case or out of range
   function automatic logic [7:0] pick_digit();
      int r;
      r = $urandom_range(19);
      if (r < 10) return 8'("0" + r);
      if (r < 16) return 8'("A" + r - 10);
      if (r < 18) return 8'("a" + $urandom_range(5));
      return (r == 18) ? 8'("G") : 8'("g");
   endfunction

   function automatic logic [7:0] pick_space();
      case ($urandom_range(3))
         0: return SPACE_BYTE;
         1: return TAB_BYTE;
         2: return CR_BYTE;
         default: return LF_BYTE;
      endcase
   endfunction

   function automatic logic [7:0] pick_junk();
      return $urandom_range(1) ? 8'($urandom_range(8'h1F)) :
                                 8'($urandom_range(8'hFF, DEL_BYTE));
   endfunction

   // random command: mostly near-valid forms with noisy spelling
   function automatic void build_random_command();
      string      base;
      int         form;
      int         target;
      logic [7:0] ch;
      cmd_bytes.delete();
      base = "";
      form = $urandom_range(9);
      // pure noise: any byte values
      if (form == 9) begin
         repeat ($urandom_range(20, 1)) cmd_bytes.push_back(8'($urandom_range(255)));
         return;
      end
      if (form <= 3) base = allow_words[$urandom_range(ALLOWED_FORMS - 1)];
      else if (form == 4) base = $sformatf("ATSP%c", pick_digit());
      else if (form == 5) base = $sformatf("ATSPA%c", pick_digit());
      else if (form == 6) base = $sformatf("ATST%c%c", pick_digit(), pick_digit());
      else begin
         base = (form == 7) ? "AT" : "";
         repeat ($urandom_range(8, 1))
            base = $sformatf("%s%c", base, 8'($urandom_range(8'h7E, 8'h21)));
      end
      // spell it out with case flips, spaces and the odd bad byte
      for (int i = 0; i < base.len(); i++) begin
         ch = base[i];
         if ($urandom_range(5) == 0) cmd_bytes.push_back(pick_space());
         if ($urandom_range(29) == 0) cmd_bytes.push_back(pick_junk());
         if (ch >= "A" && ch <= "Z" && $urandom_range(1) == 1) ch = ch + CASE_OFFSET;
         if ($urandom_range(24) == 0) ch = 8'($urandom_range(8'h7E, 8'h21));
         cmd_bytes.push_back(ch);
      end
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(4, 1)) cmd_bytes.push_back(pick_digit());
      end
      if ($urandom_range(3) == 0) begin
         cmd_bytes.push_back(CR_BYTE);
         cmd_bytes.push_back(LF_BYTE);
      end
      // pad around the raw length limit
      if ($urandom_range(9) == 0) begin
         target = $urandom_range(RAW_LIMIT + 4, RAW_LIMIT - 2);
         while (cmd_bytes.size() < target) cmd_bytes.push_back(SPACE_BYTE);
      end
   endfunction

   task automatic check_verdict(input logic [1:0] got);
      verdict_type want;
      if (verdicts_due.size() == 0) begin
         report_mismatch($sformatf("verdict %0d with none expected", got));
      end else begin
         want = verdicts_due.pop_front();
         if (got !== want)
            report_mismatch($sformatf("verdict %0d, expected %0d (%s)",
                                      got, want, want.name()));
      end
   endtask

   // result side: random pop gaps, check every verdict taken
   initial begin : verdict_sink
      int   hold;
      logic quiet_pop;
      quiet_pop = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(7) == 0) quiet_pop = !quiet_pop;
         hold = quiet_pop ? 0 : $urandom_range(MAX_IDLE);
         @(negedge clock);
         if (hold > 0) begin
            rsp_pop <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
         check_verdict(rsp_verdict);
      end
   end

   // stimulus: reset, directed table, random commands, drain
   initial begin : command_source
      int words_sent;
      words_sent = 0;
      pin_next   = 1'b0;
      clear_command();
      fill_plan();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[r]) begin
         cmd_bytes.delete();
         for (int i = 0; i < plan[r].text.len(); i++)
            cmd_bytes.push_back((i == plan[r].odd_pos) ? plan[r].odd_val :
                                                         8'(plan[r].text[i]));
         pin_next    = plan[r].pinned;
         pin_verdict = plan[r].want;
         send_command();
      end

      // random commands
      while (words_sent < RANDOM_WORDS) begin
         build_random_command();
         words_sent += cmd_bytes.size();
         send_command();
      end

      @(negedge clock);
      req_push <= 1'b0;

      // wait for the last verdicts, then drain quietly before reporting
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### filelist.f
src/at_acf_pkg.sv
src/at_acf_fifo.sv
src/at_acf_front.sv
src/at_acf_judge.sv
src/at_command_allowlist_filter.sv
tb/sv/tb_at_command_allowlist_filter.sv
